// ----- sv/lav_pkg.sv -----
// ----------------------------------------------------------------------------
// lav_pkg
// shared constants and helpers for the look-at view matrix pipeline
// ----------------------------------------------------------------------------
package lav_pkg;

  // one restoring step per root bit and per quotient bit
  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS  = 31;

  // magnitude, leading one, shift, square, sum, roots, numerator, quotients, sign
  localparam int UNIT_LAT = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;

  // eye travels from the input stage to the dot products
  localparam int EYE_DLY = 3 * UNIT_LAT + 4;

  localparam logic signed [63:0] HALF_Q30 = 64'sd536870912;
  localparam logic signed [31:0] ONE_Q30  = 32'sd1073741824;

  typedef logic signed [31:0] w32_t;
  typedef logic signed [63:0] w64_t;

  // position of the highest set bit, zero for zero
  function automatic logic [5:0] msb_pos(input logic [63:0] v);
    logic [5:0] pos;
    pos = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) pos = 6'(i);
    end
    return pos;
  endfunction

endpackage

// ----- sv/lav_unit.sv -----
// ----------------------------------------------------------------------------
// lav_unit
// pipelined normalizer: three signed components to a Q2.30 unit vector
// ----------------------------------------------------------------------------
module lav_unit import lav_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  w64_t vin [3],
  output logic out_valid,
  output w32_t uout [3]
);

  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [2:0]       neg;
    logic [2:0][29:0] mag;
    logic [61:0]      sum;
    logic [32:0]      rem;
    logic [30:0]      root;
  } sq_t;

  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [2:0]       neg;
    logic [30:0]      den;
    logic [2:0][30:0] num;
    logic [2:0][30:0] rem;
    logic [2:0][30:0] quo;
  } dv_t;

  function automatic sq_t sq_step(input sq_t s, input int p);
    sq_t         r;
    logic [34:0] rn;
    logic [34:0] trial;
    r     = s;
    rn    = {s.rem, s.sum[2*p +: 2]};
    trial = {2'b00, s.root, 2'b01};
    if (rn >= trial) begin
      r.rem  = 33'(rn - trial);
      r.root = {s.root[29:0], 1'b1};
    end else begin
      r.rem  = rn[32:0];
      r.root = {s.root[29:0], 1'b0};
    end
    return r;
  endfunction

  function automatic dv_t dv_step(input dv_t d, input int b);
    dv_t         r;
    logic [31:0] r2;
    r = d;
    for (int i = 0; i < 3; i++) begin
      r2 = {d.rem[i], d.num[i][b]};
      if (r2 >= {1'b0, d.den}) begin
        r.rem[i] = 31'(r2 - {1'b0, d.den});
        r.quo[i] = {d.quo[i][29:0], 1'b1};
      end else begin
        r.rem[i] = r2[30:0];
        r.quo[i] = {d.quo[i][29:0], 1'b0};
      end
    end
    return r;
  endfunction

  // stage 1: magnitudes and largest
  logic        s1_valid;
  logic [2:0]  s1_neg;
  logic [63:0] s1_mag [3];
  logic [63:0] s1_max;
  logic [63:0] mag_c [3];
  logic [63:0] max_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = vin[i][63] ? 64'(-vin[i]) : vin[i];
    end
    max_c = (mag_c[0] > mag_c[1]) ? mag_c[0] : mag_c[1];
    if (mag_c[2] > max_c) max_c = mag_c[2];
  end

  // stage 2: leading one
  logic        s2_valid;
  logic        s2_zero;
  logic [5:0]  s2_top;
  logic [2:0]  s2_neg;
  logic [63:0] s2_mag [3];

  // stage 3: aligned so the largest sits in [2^29, 2^30)
  logic        s3_valid;
  logic        s3_zero;
  logic [2:0]  s3_neg;
  logic [29:0] s3_mag [3];

  // stage 4: squares
  logic        s4_valid;
  logic        s4_zero;
  logic [2:0]  s4_neg;
  logic [29:0] s4_mag [3];
  logic [59:0] s4_sq [3];

  sq_t sq [SQRT_STEPS+1];
  dv_t dv [DIV_STEPS+1];

  logic [60:0] numer_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      numer_c[i] = {1'b0, sq[SQRT_STEPS].mag[i], 30'b0}
                 + 61'(sq[SQRT_STEPS].root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int j = 0; j <= SQRT_STEPS; j++) sq[j].valid <= 1'b0;
      for (int j = 0; j <= DIV_STEPS; j++) dv[j].valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      for (int i = 0; i < 3; i++) begin
        s1_neg[i] <= vin[i][63];
        s1_mag[i] <= mag_c[i];
      end
      s1_max <= max_c;

      s2_valid <= s1_valid;
      s2_zero  <= (s1_max == 64'd0);
      s2_top   <= msb_pos(s1_max);
      s2_neg   <= s1_neg;
      s2_mag   <= s1_mag;

      s3_valid <= s2_valid;
      s3_zero  <= s2_zero;
      s3_neg   <= s2_neg;
      for (int i = 0; i < 3; i++) begin
        if (s2_top > 6'd29) s3_mag[i] <= 30'(s2_mag[i] >> (s2_top - 6'd29));
        else                s3_mag[i] <= 30'(s2_mag[i] << (6'd29 - s2_top));
      end

      s4_valid <= s3_valid;
      s4_zero  <= s3_zero;
      s4_neg   <= s3_neg;
      s4_mag   <= s3_mag;
      for (int i = 0; i < 3; i++) s4_sq[i] <= s3_mag[i] * s3_mag[i];

      sq[0].valid <= s4_valid;
      sq[0].zero  <= s4_zero;
      sq[0].neg   <= s4_neg;
      for (int i = 0; i < 3; i++) sq[0].mag[i] <= s4_mag[i];
      sq[0].sum   <= 62'(s4_sq[0]) + 62'(s4_sq[1]) + 62'(s4_sq[2]);
      sq[0].rem   <= '0;
      sq[0].root  <= '0;
      for (int j = 0; j < SQRT_STEPS; j++) sq[j+1] <= sq_step(sq[j], SQRT_STEPS - 1 - j);

      dv[0].valid <= sq[SQRT_STEPS].valid;
      dv[0].zero  <= sq[SQRT_STEPS].zero;
      dv[0].neg   <= sq[SQRT_STEPS].neg;
      dv[0].den   <= sq[SQRT_STEPS].zero ? 31'd1 : sq[SQRT_STEPS].root;
      for (int i = 0; i < 3; i++) begin
        dv[0].num[i] <= numer_c[i][30:0];
        dv[0].rem[i] <= {1'b0, numer_c[i][60:31]};
        dv[0].quo[i] <= '0;
      end
      for (int j = 0; j < DIV_STEPS; j++) dv[j+1] <= dv_step(dv[j], DIV_STEPS - 1 - j);

      out_valid <= dv[DIV_STEPS].valid;
      for (int i = 0; i < 3; i++) begin
        if (dv[DIV_STEPS].zero)        uout[i] <= '0;
        else if (dv[DIV_STEPS].neg[i]) uout[i] <= -w32_t'({1'b0, dv[DIV_STEPS].quo[i]});
        else                           uout[i] <= w32_t'({1'b0, dv[DIV_STEPS].quo[i]});
      end
    end
  end

endmodule

// ----- sv/look_at_view_matrix.sv -----
// throughput: one item per cycle while not stalled; each normalizer is 69 register stages with a
//   one-bit-per-stage square root and three one-bit-per-stage dividers
// a stall on m_tready freezes the whole pipeline and drops s_tready
// reset: rst clears all valid bits; payload registers are not reset
// ----------------------------------------------------------------------------
// look_at_view_matrix
// streams eye, target and up vectors into camera view matrix rows and shifts
// ----------------------------------------------------------------------------
module look_at_view_matrix import lav_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, upvec_x, upvec_y, upvec_z
  input  logic [287:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // right_x/y/z, true_up_x/y/z, back_x/y/z, shift_x/y/z
  output logic [383:0] m_tdata
);

  // the whole pipeline advances together unless a finished result is held
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  w32_t in_eye [3];
  w32_t in_tgt [3];
  w32_t in_up  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_eye[i] = s_tdata[32*i +: 32];
      in_tgt[i] = s_tdata[96 + 32*i +: 32];
      in_up[i]  = s_tdata[192 + 32*i +: 32];
    end
  end

  // input stage: eye minus target
  logic s0_valid;
  w64_t s0_diff [3];
  w32_t s0_eye  [3];
  w32_t s0_up   [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= s_tvalid;
      for (int i = 0; i < 3; i++) begin
        s0_diff[i] <= w64_t'(in_eye[i]) - w64_t'(in_tgt[i]);
        s0_eye[i]  <= in_eye[i];
        s0_up[i]   <= in_up[i];
      end
    end
  end

  // back axis
  logic bk_valid;
  w32_t bk [3];

  lav_unit u_back (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s0_valid), .vin(s0_diff),
    .out_valid(bk_valid), .uout(bk)
  );

  // eye and up ride alongside the normalizers
  w32_t up_dly  [UNIT_LAT][3];
  w32_t eye_dly [EYE_DLY][3];

  always_ff @(posedge clk) begin
    if (en) begin
      up_dly[0]  <= s0_up;
      eye_dly[0] <= s0_eye;
      for (int j = 1; j < UNIT_LAT; j++) up_dly[j] <= up_dly[j-1];
      for (int j = 1; j < EYE_DLY; j++) eye_dly[j] <= eye_dly[j-1];
    end
  end

  // up cross back: products, then differences
  logic c1m_valid;
  w64_t c1m_p  [6];
  w32_t c1m_bk [3];
  logic c1s_valid;
  w64_t c1s_r  [3];
  w32_t c1s_bk [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      c1m_valid <= 1'b0;
      c1s_valid <= 1'b0;
    end else if (en) begin
      c1m_valid <= bk_valid;
      c1m_bk    <= bk;
      c1m_p[0]  <= w64_t'(up_dly[UNIT_LAT-1][1]) * w64_t'(bk[2]);
      c1m_p[1]  <= w64_t'(up_dly[UNIT_LAT-1][2]) * w64_t'(bk[1]);
      c1m_p[2]  <= w64_t'(up_dly[UNIT_LAT-1][2]) * w64_t'(bk[0]);
      c1m_p[3]  <= w64_t'(up_dly[UNIT_LAT-1][0]) * w64_t'(bk[2]);
      c1m_p[4]  <= w64_t'(up_dly[UNIT_LAT-1][0]) * w64_t'(bk[1]);
      c1m_p[5]  <= w64_t'(up_dly[UNIT_LAT-1][1]) * w64_t'(bk[0]);

      c1s_valid <= c1m_valid;
      c1s_bk    <= c1m_bk;
      c1s_r[0]  <= c1m_p[0] - c1m_p[1];
      c1s_r[1]  <= c1m_p[2] - c1m_p[3];
      c1s_r[2]  <= c1m_p[4] - c1m_p[5];
    end
  end

  // right axis
  logic rt_valid;
  w32_t rt [3];

  lav_unit u_right (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(c1s_valid), .vin(c1s_r),
    .out_valid(rt_valid), .uout(rt)
  );

  w32_t bk_dly1 [UNIT_LAT][3];

  always_ff @(posedge clk) begin
    if (en) begin
      bk_dly1[0] <= c1s_bk;
      for (int j = 1; j < UNIT_LAT; j++) bk_dly1[j] <= bk_dly1[j-1];
    end
  end

  // back cross right
  logic c2m_valid;
  w64_t c2m_p  [6];
  w32_t c2m_bk [3];
  w32_t c2m_rt [3];
  logic c2s_valid;
  w64_t c2s_r  [3];
  w32_t c2s_bk [3];
  w32_t c2s_rt [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      c2m_valid <= 1'b0;
      c2s_valid <= 1'b0;
    end else if (en) begin
      c2m_valid <= rt_valid;
      c2m_bk    <= bk_dly1[UNIT_LAT-1];
      c2m_rt    <= rt;
      c2m_p[0]  <= w64_t'(bk_dly1[UNIT_LAT-1][1]) * w64_t'(rt[2]);
      c2m_p[1]  <= w64_t'(bk_dly1[UNIT_LAT-1][2]) * w64_t'(rt[1]);
      c2m_p[2]  <= w64_t'(bk_dly1[UNIT_LAT-1][2]) * w64_t'(rt[0]);
      c2m_p[3]  <= w64_t'(bk_dly1[UNIT_LAT-1][0]) * w64_t'(rt[2]);
      c2m_p[4]  <= w64_t'(bk_dly1[UNIT_LAT-1][0]) * w64_t'(rt[1]);
      c2m_p[5]  <= w64_t'(bk_dly1[UNIT_LAT-1][1]) * w64_t'(rt[0]);

      c2s_valid <= c2m_valid;
      c2s_bk    <= c2m_bk;
      c2s_rt    <= c2m_rt;
      c2s_r[0]  <= c2m_p[0] - c2m_p[1];
      c2s_r[1]  <= c2m_p[2] - c2m_p[3];
      c2s_r[2]  <= c2m_p[4] - c2m_p[5];
    end
  end

  // true up axis
  logic tu_valid;
  w32_t tu [3];

  lav_unit u_true_up (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(c2s_valid), .vin(c2s_r),
    .out_valid(tu_valid), .uout(tu)
  );

  w32_t bk_dly2 [UNIT_LAT][3];
  w32_t rt_dly  [UNIT_LAT][3];

  always_ff @(posedge clk) begin
    if (en) begin
      bk_dly2[0] <= c2s_bk;
      rt_dly[0]  <= c2s_rt;
      for (int j = 1; j < UNIT_LAT; j++) begin
        bk_dly2[j] <= bk_dly2[j-1];
        rt_dly[j]  <= rt_dly[j-1];
      end
    end
  end

  // rows times eye: nine products, then rounded sums, then negate and clamp
  logic dm_valid;
  w64_t dm_p   [3][3];
  w32_t dm_row [3][3];
  logic ds_valid;
  w64_t ds_t   [3];
  w32_t ds_row [3][3];
  w32_t row_c  [3][3];

  always_comb begin
    row_c[0] = rt_dly[UNIT_LAT-1];
    row_c[1] = tu;
    row_c[2] = bk_dly2[UNIT_LAT-1];
  end

  w32_t out_row   [3][3];
  w32_t out_shift [3];

  // floor by 2^30, negate, clamp to 32 bits
  function automatic w32_t sat_neg(input w64_t t);
    logic signed [33:0] q;
    logic signed [34:0] nq;
    q  = t[63:30];
    nq = -35'(q);
    if (nq > 35'sd2147483647)       return 32'sh7fffffff;
    else if (nq < -35'sd2147483648) return 32'sh80000000;
    else                            return nq[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      dm_valid <= 1'b0;
      ds_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      dm_valid <= tu_valid;
      dm_row   <= row_c;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          dm_p[r][c] <= w64_t'(row_c[r][c]) * w64_t'(eye_dly[EYE_DLY-1][c]);
        end
      end

      ds_valid <= dm_valid;
      ds_row   <= dm_row;
      for (int r = 0; r < 3; r++) ds_t[r] <= dm_p[r][0] + dm_p[r][1] + dm_p[r][2] + HALF_Q30;

      m_tvalid <= ds_valid;
      out_row  <= ds_row;
      for (int r = 0; r < 3; r++) out_shift[r] <= sat_neg(ds_t[r]);
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) m_tdata[96*r + 32*c +: 32] = out_row[r][c];
      m_tdata[288 + 32*r +: 32] = out_shift[r];
    end
  end

`ifndef ASSERT_OFF
  // a zero back axis forces the right and true up rows and the back shift to zero
  a_zero_back: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_row[2][0] == 0 && out_row[2][1] == 0 && out_row[2][2] == 0)
    |-> (out_row[0][0] == 0 && out_row[0][1] == 0 && out_row[0][2] == 0 &&
         out_row[1][0] == 0 && out_row[1][1] == 0 && out_row[1][2] == 0 &&
         out_shift[2] == 0))
    else $error("nonzero rows with zero back axis");

  // a zero right axis leaves no true up axis
  a_zero_right: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_row[0][0] == 0 && out_row[0][1] == 0 && out_row[0][2] == 0)
    |-> (out_row[1][0] == 0 && out_row[1][1] == 0 && out_row[1][2] == 0))
    else $error("true up nonzero with zero right axis");

  // the diagonal unit components never exceed one in magnitude
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_row[0][0] <= ONE_Q30 && out_row[0][0] >= -ONE_Q30 &&
                  out_row[1][1] <= ONE_Q30 && out_row[1][1] >= -ONE_Q30 &&
                  out_row[2][2] <= ONE_Q30 && out_row[2][2] >= -ONE_Q30))
    else $error("unit component out of range");

  // a held result stays put while the pipeline is frozen
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed during stall");
`endif

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// streams camera requests into the view matrix pipeline and compares every
// output row and shift against a bit-exact behavioral camera model
// ----------------------------------------------------------------------------

class view_scoreboard;
  logic [383:0] pending_views[$];
  int mismatches;

  // exact normalizer: shift magnitudes so the largest sits in [2^29, 2^30)
  static function void unit_vec(input logic signed [63:0] v[3],
                                 output logic signed [63:0] u[3]);
    logic [63:0] mag[3];
    logic [63:0] mx, sum, len, q;
    logic [127:0] num;
    int top;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i][63] ? 64'(-v[i]) : 64'(v[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return;
    end
    top = 0;
    while ((mx >> top) > 1) top++;
    for (int i = 0; i < 3; i++) begin
      if (top > 29) mag[i] = mag[i] >> (top - 29);
      else mag[i] = mag[i] << (29 - top);
    end
    sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    len = root_floor(sum);
    for (int i = 0; i < 3; i++) begin
      num = ({64'd0, mag[i]} << 30) + (len >> 1);
      q = 64'(num / len);
      u[i] = v[i][63] ? -$signed(q) : $signed(q);
    end
  endfunction

  static function logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  static function void cross_vec(input logic signed [63:0] a[3],
                                 input logic signed [63:0] b[3],
                                 output logic signed [63:0] c[3]);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // rounded, negated and saturated translation
  static function logic [31:0] shift_calc(input logic signed [63:0] row[3],
                                          input logic signed [63:0] eye[3]);
    logic signed [127:0] d, q;
    d = 128'(row[0]) * 128'(eye[0]) + 128'(row[1]) * 128'(eye[1])
      + 128'(row[2]) * 128'(eye[2]);
    d = 64'(d) + (128'sd1 <<< 29);
    d = 128'($signed(64'(d)));
    q = -(d >>> 30);
    if (q > 128'sh7FFFFFFF) q = 128'sh7FFFFFFF;
    if (q < -128'sh80000000) q = -128'sh80000000;
    return q[31:0];
  endfunction

  function void note_request(input logic [287:0] req);
    logic signed [63:0] eye[3], diff[3], up[3], back[3], rr[3], rt[3], ur[3], tu[3];
    logic [383:0] view;
    for (int i = 0; i < 3; i++) begin
      eye[i] = 64'($signed(req[32*i +: 32]));
      diff[i] = eye[i] - 64'($signed(req[32*(3+i) +: 32]));
      up[i] = 64'($signed(req[32*(6+i) +: 32]));
    end
    unit_vec(diff, back);
    cross_vec(up, back, rr);
    unit_vec(rr, rt);
    cross_vec(back, rt, ur);
    unit_vec(ur, tu);
    for (int i = 0; i < 3; i++) begin
      view[32*i +: 32] = rt[i][31:0];
      view[32*(3+i) +: 32] = tu[i][31:0];
      view[32*(6+i) +: 32] = back[i][31:0];
    end
    view[32*9 +: 32] = shift_calc(rt, eye);
    view[32*10 +: 32] = shift_calc(tu, eye);
    view[32*11 +: 32] = shift_calc(back, eye);
    pending_views.push_back(view);
  endfunction

  function void check_view(input logic [383:0] got);
    logic [383:0] want;
    if (pending_views.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    want = pending_views.pop_front();
    for (int f = 0; f < 12; f++) begin
      if (got[32*f +: 32] !== want[32*f +: 32]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("field %0d: expected %h, got %h", f, want[32*f +: 32], got[32*f +: 32]);
      end
    end
  endfunction
endclass

module tb;
  import lav_pkg::*;

  localparam int LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 800;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [287:0] s_tdata;   // eye x/y/z, target x/y/z, up x/y/z from bit 0 up
  logic m_tvalid;
  logic m_tready;
  logic [383:0] m_tdata;   // right x/y/z, true up x/y/z, back x/y/z, shift x/y/z

  view_scoreboard views;
  int send_idle_pct;       // sender idle chance in percent
  int recv_stall_pct;      // receiver stall chance in percent
  bit hold_recv;           // long receiver hold-off
  int cycles;

  look_at_view_matrix uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // timeout watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus the long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) views.check_view(m_tdata);
      m_tready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // input transfer monitor feeds the prediction
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) views.note_request(s_tdata);
  end

  function automatic logic [31:0] rand_coord(input int style);
    case (style)
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000000)) - 1000000);
      2: return 32'($signed($urandom_range(64)) - 32);
      default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  // one transfer, with optional idle cycles first
  task automatic send_request(input logic [287:0] req);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= req;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random(input int n);
    logic [287:0] req;
    int style;
    for (int k = 0; k < n; k++) begin
      style = $urandom_range(9);
      for (int f = 0; f < 9; f++)
        req[32*f +: 32] = rand_coord(style < 4 ? 0 : style < 7 ? 1 : style < 9 ? 2 : 3);
      // up parallel to the view axis now and then
      if ($urandom_range(19) == 0)
        for (int f = 0; f < 3; f++)
          req[32*(6+f) +: 32] = req[32*f +: 32] - req[32*(3+f) +: 32];
      // eye on target now and then
      if ($urandom_range(19) == 0) req[191:96] = req[95:0];
      send_request(req);
    end
    s_tvalid <= 1'b0;
  endtask

  task automatic drain;
    while (views.pending_views.size() != 0) @(posedge clk);
  endtask

  function automatic logic [287:0] pack_req(input int ex, ey, ez, tx, ty, tz, ux, uy, uz);
    return {32'(uz), 32'(uy), 32'(ux), 32'(tz), 32'(ty), 32'(tx), 32'(ez), 32'(ey), 32'(ex)};
  endfunction

  initial begin
    views = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_recv = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: plain camera, eye on target, zero up, up along the view axis,
    // field extremes and saturating shifts
    send_request(pack_req(0, 0, 327680, 0, 0, 0, 0, 65536, 0));
    send_request(pack_req(65536, 65536, 65536, 65536, 65536, 65536, 0, 65536, 0));
    send_request(pack_req(0, 0, 65536, 0, 0, 0, 0, 0, 0));
    send_request(pack_req(0, 0, 65536, 0, 0, 0, 0, 0, 131072));
    send_request(pack_req(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                          32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 0));
    send_request(pack_req(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                          32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1));
    send_request(pack_req(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 1, 1, 1));
    send_request(pack_req(1, 0, 0, 0, 0, 0, 0, 1, 0));
    send_request(pack_req(-1, -1, -1, 0, 0, 0, -1, 1, -1));
    send_request(pack_req(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                          32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
    send_request(pack_req(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                          32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
    s_tvalid <= 1'b0;
    drain();

    // sender idle and receiver stall phases
    send_random(RANDOM_ITEMS / 5);
    send_idle_pct = 76;
    send_random(RANDOM_ITEMS / 5);
    send_idle_pct = 0;
    recv_stall_pct = 76;
    send_random(RANDOM_ITEMS / 5);
    send_idle_pct = 29;
    recv_stall_pct = 29;
    send_random(RANDOM_ITEMS / 5);

    // sender pauses until everything is out
    drain();

    // long receiver hold-off while the sender keeps pushing; the sender is
    // slowed so it is still offering when the first result reaches the
    // output, which freezes the pipe and drops s_tready
    send_idle_pct = 50;
    recv_stall_pct = 0;
    fork
      begin
        hold_recv = 1'b1;
        repeat (600) @(posedge clk);
        hold_recv = 1'b0;
      end
      send_random(RANDOM_ITEMS / 5);
    join

    drain();
    repeat (3 * UNIT_LAT + 20) @(posedge clk);
    if (views.mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
